### rtl/core/qrs_pkg.sv
// Shared constants and GF(256) helpers for the QR Reed-Solomon parity encoder.
// Holds the generator exponent table, field polynomial and queue sizing.
// No dependencies.
package qrs_pkg;

  localparam int unsigned PARITY_COUNT_DEF = 17;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam logic [8:0]  GF_POLY          = 9'h11d;

  // Generator coefficients as powers of alpha, x^17 term first.
  localparam logic [7:0] GEN_EXP [18] = '{
    8'd0,   8'd43,  8'd139, 8'd206, 8'd78,  8'd43,  8'd239, 8'd123, 8'd206,
    8'd214, 8'd147, 8'd24,  8'd99,  8'd150, 8'd39,  8'd243, 8'd163, 8'd136
  };

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // alpha^e, evaluated at elaboration for the fixed generator taps.
  function automatic logic [7:0] alpha_pow(input logic [7:0] e);
    logic [8:0] v;
    int unsigned k;
    v = 9'd1;
    for (k = 0; k < 32'(e); k++) begin
      v = {v[7:0], 1'b0};
      if (v[8]) begin
        v = v ^ GF_POLY;
      end
    end
    return v[7:0];
  endfunction

  // Shift-and-add multiply in GF(256).
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    int k;
    x   = {1'b0, a};
    acc = 8'd0;
    for (k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

endpackage

### rtl/core/qrs_front.sv
// Front end: accepts data codewords and folds them into the remainder LFSR.
// Pushes a finished remainder into the queue on the last codeword. Uses qrs_pkg.
module qrs_front #(
  parameter int unsigned PARITY_COUNT = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_data_byte_i,
  input  logic                          in_last_data_i,
  input  qrs_pkg::queue_status_t        queue_status_i,
  output logic                          push_o,
  output logic [PARITY_COUNT-1:0][7:0]  push_data_o
);
  import qrs_pkg::*;

  logic [PARITY_COUNT-1:0][7:0] rem_q, rem_d, rem_next;
  logic [7:0] fb;
  logic       accept;

  assign in_stall_o = queue_status_i.full;
  assign accept     = in_valid_i && !queue_status_i.full;
  assign fb         = in_data_byte_i ^ rem_q[0];

  for (genvar i = 0; i < PARITY_COUNT; i++) begin : g_tap
    localparam logic [7:0] Coef = alpha_pow(GEN_EXP[i+1]);
    if (i < PARITY_COUNT - 1) begin : g_mid
      assign rem_next[i] = rem_q[i+1] ^ gf_mul(fb, Coef);
    end else begin : g_end
      assign rem_next[i] = gf_mul(fb, Coef);
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (accept) begin
      rem_d = in_last_data_i ? '0 : rem_next;
    end
  end

  assign push_o      = accept && in_last_data_i;
  assign push_data_o = rem_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

### rtl/core/qrs_queue.sv
// Short queue of finished remainders between front and back end.
// Register array with read and write pointers. Uses qrs_pkg.
module qrs_queue #(
  parameter int unsigned PARITY_COUNT = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [PARITY_COUNT-1:0][7:0]  push_data_i,
  input  logic                          pop_i,
  output logic [PARITY_COUNT-1:0][7:0]  head_o,
  output qrs_pkg::queue_status_t        status_o
);
  import qrs_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [PARITY_COUNT-1:0][7:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/core/qrs_back.sv
// Back end: walks the queue head byte by byte into the output register.
// Pops the entry after its final byte. Uses qrs_pkg.
module qrs_back #(
  parameter int unsigned PARITY_COUNT = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [PARITY_COUNT-1:0][7:0]  head_i,
  input  qrs_pkg::queue_status_t        queue_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_parity_byte_o,
  output logic                          out_last_parity_o
);
  import qrs_pkg::*;

  localparam int unsigned IdxW = $clog2(PARITY_COUNT);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic            load, final_byte;

  assign final_byte = (idx_q == IdxW'(PARITY_COUNT - 1));
  assign load  = (!valid_q || !out_stall_i) && !queue_status_i.empty;
  assign pop_o = load && final_byte;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (!valid_q || !out_stall_i) begin
      valid_d = load;
    end
    if (load) begin
      byte_d = head_i[idx_q];
      last_d = final_byte;
      idx_d  = final_byte ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign out_valid_o       = valid_q;
  assign out_parity_byte_o = byte_q;
  assign out_last_parity_o = last_q;

endmodule

### rtl/core/qr_reed_solomon_parity_encoder.sv
// QR-code Reed-Solomon parity encoder: 17 EC codewords over GF(256), poly 0x11D.
// Top level tying front end, remainder queue and back end. Uses qrs_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one data codeword per
//   request; in_last_data_i marks the final codeword of a message. Output
//   channel (out_valid_o / out_stall_i) carries the 17 parity codewords of
//   each message, highest degree first, out_last_parity_o set on the 17th.
//   Throughput: one data codeword per cycle while the queue is not full. The
//   remainder LFSR updates all 17 bytes in the cycle the codeword is taken.
//   Once the last data codeword is taken, its remainder is pushed into the
//   queue and loaded into the output register byte by byte; the bytes follow
//   at one per cycle while not stalled. The output side drains each message
//   through one output register; finished remainders wait in a two-entry
//   queue, so the input only stalls when two parity bursts are already pending.
//   Reset clears the remainder, empties the queue and drops out_valid_o.
//   A stalled output holds its byte and flag; the front keeps taking data until the queue is full.
module qr_reed_solomon_parity_encoder #(
  parameter int unsigned PARITY_COUNT = qrs_pkg::PARITY_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_data_byte_i,
  input  logic       in_last_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_parity_byte_o,
  output logic       out_last_parity_o
);
  import qrs_pkg::*;

  logic                         push, pop;
  logic [PARITY_COUNT-1:0][7:0] push_data, head;
  queue_status_t                queue_status;

  // Front: fold codewords, push the remainder on the last one.
  qrs_front #(.PARITY_COUNT(PARITY_COUNT)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_byte_i,
    .in_last_data_i,
    .queue_status_i (queue_status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // Queue: hold finished remainders until the back end drains them.
  qrs_queue #(.PARITY_COUNT(PARITY_COUNT)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (queue_status)
  );

  // Back: serialize the head entry one byte per cycle while the output is not stalled.
  qrs_back #(.PARITY_COUNT(PARITY_COUNT)) u_back (
    .clk_i,
    .rst_ni,
    .head_i         (head),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .out_valid_o,
    .out_stall_i,
    .out_parity_byte_o,
    .out_last_parity_o
  );

  // A last codeword taken always leaves a remainder queued.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_last_data_i) |=> !queue_status.empty)
    else $error("accepted last codeword left queue empty");

  // Input stalls only behind a full queue, never an empty one.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !queue_status.empty)
    else $error("input stalled with empty queue");

  // A pop only happens while a byte is being loaded from a queued entry.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !queue_status.empty)
    else $error("pop from empty queue");

  // After the final parity byte leaves, the next output cannot be final too.
  a_last_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_last_parity_o) |=>
      !(out_valid_o && out_last_parity_o))
    else $error("back-to-back final parity flags");

endmodule

### bench/qr_reed_solomon_parity_encoder_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the QR Reed-Solomon parity encoder (17 EC codewords).
// Holds a parity scoreboard class with its own GF(256) division and the driving top.
// Depends only on the encoder RTL and its package.

localparam int unsigned ECC_LEN    = 17;
localparam logic [8:0]  FIELD_POLY = 9'h11d;

// Generator coefficients as powers of alpha, x^17 term first.
localparam logic [7:0] GEN_LOG [ECC_LEN + 1] = '{
  8'd0,   8'd43,  8'd139, 8'd206, 8'd78,  8'd43,  8'd239, 8'd123, 8'd206,
  8'd214, 8'd147, 8'd24,  8'd99,  8'd150, 8'd39,  8'd243, 8'd163, 8'd136
};

typedef struct packed {
  logic [7:0] parity;
  logic       last;
} parity_word_t;

class parity_scoreboard;
  logic [7:0]   remainder_q [ECC_LEN];
  logic [7:0]   tap [ECC_LEN];
  parity_word_t expected_q [$];
  int           mismatches;
  int           codewords_seen;
  int           messages_seen;
  int           parity_seen;

  function new();
    for (int i = 0; i < ECC_LEN; i++) begin
      remainder_q[i] = 8'd0;
      tap[i]         = alpha_to(GEN_LOG[i + 1]);
    end
    mismatches     = 0;
    codewords_seen = 0;
    messages_seen  = 0;
    parity_seen    = 0;
  endfunction

  function logic [7:0] alpha_to(logic [7:0] e);
    logic [8:0] v;
    v = 9'd1;
    for (int k = 0; k < int'(e); k++) begin
      v = {v[7:0], 1'b0};
      if (v[8]) v = v ^ FIELD_POLY;
    end
    return v[7:0];
  endfunction

  function logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ FIELD_POLY;
    end
    return acc;
  endfunction

  // Fold one accepted codeword into the remainder; on the last one queue the burst.
  function void note_codeword(logic [7:0] data, logic last);
    logic [7:0]   feedback;
    parity_word_t word;
    feedback = data ^ remainder_q[0];
    for (int i = 0; i < ECC_LEN - 1; i++)
      remainder_q[i] = remainder_q[i + 1] ^ gf_times(feedback, tap[i]);
    remainder_q[ECC_LEN - 1] = gf_times(feedback, tap[ECC_LEN - 1]);
    codewords_seen++;
    if (last) begin
      for (int i = 0; i < ECC_LEN; i++) begin
        word.parity = remainder_q[i];
        word.last   = (i == ECC_LEN - 1);
        expected_q.push_back(word);
        remainder_q[i] = 8'd0;
      end
      messages_seen++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task check_parity(logic [7:0] value, logic last);
    parity_word_t want;
    parity_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("parity byte %02h with no burst pending", value));
    end else begin
      want = expected_q.pop_front();
      if (value !== want.parity)
        report($sformatf("parity byte %02h, want %02h", value, want.parity));
      if (last !== want.last)
        report($sformatf("last flag %b, want %b", last, want.last));
    end
  endtask
endclass

module qr_reed_solomon_parity_encoder_test;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_data = 8'd0;
  logic       in_last = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_parity_byte_o;
  logic       out_last_parity_o;

  parity_scoreboard parity_sb = new();

  // Sender burst bookkeeping and the request for a long receiver hold-off.
  int burst_left = 0;
  bit hold_request = 1'b0;

  qr_reed_solomon_parity_encoder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .in_data_byte_i    (in_data),
    .in_last_data_i    (in_last),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .out_parity_byte_o (out_parity_byte_o),
    .out_last_parity_o (out_last_parity_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("qr_reed_solomon_parity_encoder_test failed");
    $finish;
  end

  // Offer one codeword and hold it until taken. Call at a rising edge.
  // Acceptance is judged at the falling edge, where stall is settled, and
  // takes effect at the rising edge after it.
  task automatic send_codeword(input logic [7:0] data, input logic last);
    bit taken;
    int gap;
    if (burst_left == 0) begin
      // Start a new burst; sometimes with no gap at all so stretches run back to back.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= data;
    in_last  <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) parity_sb.note_codeword(data, last);
      @(posedge clk_i);
    end while (!taken);
    burst_left--;
  endtask

  // Send a message of random bytes; the final byte carries the last mark.
  task automatic send_random_message(input int length);
    for (int i = 0; i < length; i++)
      send_codeword(8'($urandom_range(0, 255)), i == length - 1);
  endtask

  // Stop offering requests until every queued parity byte has come out.
  task automatic drain_parity();
    in_valid   <= 1'b0;
    burst_left  = 0;
    while (parity_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: stall on a randomly picked mode that is picked anew each phase,
  // or hold off entirely for a long stretch when the sender asks for it.
  initial begin : receiver
    int hold_left;
    int mode;
    int phase_cycles;
    hold_left    = 0;
    mode         = 0;
    phase_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (phase_cycles == 0) begin
        mode         = $urandom_range(0, 3);
        phase_cycles = 48;
      end
      phase_cycles--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 7) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= phase_cycles[0];
        endcase
      end
    end
  end

  // Check every parity byte the receiver takes, at the falling edge where it is stable.
  initial begin : parity_monitor
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall)
        parity_sb.check_parity(out_parity_byte_o, out_last_parity_o);
    end
  end

  initial begin : stimulus
    int msg_count;
    int length;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-byte messages at both extremes, zero codewords that must
    // not be skipped, walking ones, and an all-ones run ending in zero.
    send_codeword(8'h00, 1'b1);
    send_codeword(8'hff, 1'b1);
    send_codeword(8'h00, 1'b0);
    send_codeword(8'h00, 1'b0);
    send_codeword(8'h00, 1'b0);
    send_codeword(8'h01, 1'b1);
    for (int i = 0; i < 8; i++)
      send_codeword(8'(1 << i), i == 7);
    send_codeword(8'hff, 1'b0);
    send_codeword(8'hff, 1'b0);
    send_codeword(8'h00, 1'b1);
    drain_parity();

    // Random messages, mostly short with the odd long one.
    msg_count = 0;
    while (parity_sb.codewords_seen < 217) begin
      if (msg_count == 6) begin
        // Stall the output for a long stretch and keep offering short
        // messages, so the remainder queue fills and the input stalls.
        hold_request = 1'b1;
        for (int k = 0; k < 4; k++)
          send_random_message($urandom_range(1, 3));
      end
      if (msg_count == 14) drain_parity();
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      send_random_message(length);
      msg_count++;
    end

    drain_parity();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d messages (%0d data codewords), %0d parity bytes checked,",
             parity_sb.messages_seen, parity_sb.codewords_seen, parity_sb.parity_seen);
    $display("including a long output hold-off and idle pauses on both sides.");
    if (parity_sb.mismatches == 0 && parity_sb.pending() == 0) begin
      $display("qr_reed_solomon_parity_encoder_test passed");
    end else begin
      $display("qr_reed_solomon_parity_encoder_test failed");
    end
    $finish;
  end

endmodule

### qr_reed_solomon_parity_encoder.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_queue.sv
rtl/core/qrs_back.sv
rtl/core/qr_reed_solomon_parity_encoder.sv
bench/qr_reed_solomon_parity_encoder_test.sv
